// ===== design/cgcd_pkg.sv =====
package cgcd_pkg;

    // Build-time sizes
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 16;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = 16;
    localparam int RCOL_W   = 10;
    localparam int GRAD_W   = 18;
    localparam int DIFF_W   = PIXEL_BITS + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(2);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic signed [PIXEL_BITS-1:0] t_pixel;
    typedef logic signed [GRAD_W-1:0]     t_grad;
    typedef logic [COL_W-1:0]             t_col;
    typedef logic [ROW_W-1:0]             t_row;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
    } t_cfg;

    // One classified pixel: the result for the row above, and its own when on the last row
    typedef struct packed {
        t_grad grad_up;
        t_grad grad_own;
        t_row  row;
        t_col  col;
        logic  last_row;
        logic  row_end;
    } t_job;

endpackage

// ===== design/cgcd_if.sv =====
interface cgcd_pix_if;
    logic                   valid;
    logic                   ready;
    cgcd_pkg::t_pixel       pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface cgcd_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [cgcd_pkg::GRAD_W-1:0] gradient_half_units;
    logic [cgcd_pkg::ROW_W-1:0]         result_row;
    logic [cgcd_pkg::RCOL_W-1:0]        result_column;
    logic                               last_of_run;
    logic                               frame_done;

    modport source (output valid, output gradient_half_units, output result_row,
                    output result_column, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input gradient_half_units, input result_row,
                    input result_column, input last_of_run, input frame_done,
                    output ready);
endinterface

interface cgcd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cgcd_pkg::CFG_IDX_W-1:0]     index;
    logic [cgcd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cgcd_front.sv =====
module cgcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cgcd_pix_if.sink         i_pix,
    input  cgcd_pkg::t_cfg   i_cfg,
    output logic             o_push_valid,
    output cgcd_pkg::t_job   o_job,
    input  logic             i_push_ready
);

    // Line buffers
    cgcd_pkg::t_pixel r_prev_mem [cgcd_pkg::MAX_WIDTH];
    cgcd_pkg::t_pixel r_old_mem  [cgcd_pkg::MAX_WIDTH];

    logic              r_col_valid;
    cgcd_pkg::t_col    r_col, n_col;
    cgcd_pkg::t_row    r_row, n_row;

    logic              r_s2_valid;
    cgcd_pkg::t_pixel  r_s2_x;
    cgcd_pkg::t_col    r_s2_col;
    cgcd_pkg::t_row    r_s2_row;
    logic              r_s2_last_row;
    logic              r_s2_row_end;
    cgcd_pkg::t_pixel  r_rd_prev;
    cgcd_pkg::t_pixel  r_rd_old;

    logic [31:0]       w_lim;
    logic [31:0]       h_lim;
    logic              row_end;
    logic              last_row;
    logic              s2_adv;
    logic              in_acc;
    logic              s2_push;
    logic              fwd_hit;
    logic signed [cgcd_pkg::DIFF_W-1:0] d_prev;
    logic signed [cgcd_pkg::DIFF_W-1:0] d_old;

    // Clamp the registers to their legal ranges
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_lim = 32'd1;
        end else if (32'(i_cfg.image_width) > 32'(cgcd_pkg::MAX_WIDTH)) begin
            w_lim = 32'(cgcd_pkg::MAX_WIDTH);
        end else begin
            w_lim = 32'(i_cfg.image_width);
        end
        if (i_cfg.image_height < cgcd_pkg::HEIGHT_W'(2)) begin
            h_lim = 32'd2;
        end else begin
            h_lim = 32'(i_cfg.image_height);
        end
    end

    assign row_end  = (32'(r_col) + 32'd1) >= w_lim;
    assign last_row = (32'(r_row) + 32'd1) >= h_lim;

    assign s2_push      = r_s2_valid && (r_s2_row != '0);
    assign s2_adv       = r_s2_valid && (!s2_push || i_push_ready);
    assign i_pix.ready  = !r_s2_valid || s2_adv;
    assign in_acc       = i_pix.valid && i_pix.ready;
    assign fwd_hit      = s2_adv && (r_s2_col == r_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : cgcd_pkg::ROW_W'(r_row + 1'b1);
            end else begin
                n_col = cgcd_pkg::COL_W'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s2_valid  <= 1'b0;
            r_col_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_valid <= 1'b1;
            if (in_acc) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // Stage two payload and line buffer read; bypass the write leaving this edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_x        <= i_pix.pixel_value;
            r_s2_col      <= r_col;
            r_s2_row      <= r_row;
            r_s2_last_row <= last_row;
            r_s2_row_end  <= row_end;
            r_rd_prev     <= fwd_hit ? r_s2_x    : r_prev_mem[r_col];
            r_rd_old      <= fwd_hit ? r_rd_prev : r_old_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_prev_mem[r_s2_col] <= r_s2_x;
            r_old_mem[r_s2_col]  <= r_rd_prev;
        end
    end

    assign d_prev = cgcd_pkg::DIFF_W'(r_s2_x) - cgcd_pkg::DIFF_W'(r_rd_prev);
    assign d_old  = cgcd_pkg::DIFF_W'(r_s2_x) - cgcd_pkg::DIFF_W'(r_rd_old);

    always_comb begin
        o_job.grad_own = cgcd_pkg::GRAD_W'({d_prev, 1'b0});
        if (r_s2_row == cgcd_pkg::ROW_W'(1)) begin
            o_job.grad_up = cgcd_pkg::GRAD_W'({d_prev, 1'b0});
        end else begin
            o_job.grad_up = cgcd_pkg::GRAD_W'(d_old);
        end
        o_job.row      = r_s2_row;
        o_job.col      = r_s2_col;
        o_job.last_row = r_s2_last_row;
        o_job.row_end  = r_s2_row_end;
    end

    assign o_push_valid = s2_push;

    a_accept_fills_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s2_valid)
        else $error("accepted pixel did not reach stage two");

    a_row_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && row_end) |=> (r_col == '0))
        else $error("column counter did not wrap at row end");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_valid && r_s2_valid && s2_push && !i_push_ready) |=>
        (r_s2_valid && $stable(r_s2_col) && $stable(r_s2_x)))
        else $error("stage two lost its item while the queue was full");

endmodule

// ===== design/cgcd_queue.sv =====
module cgcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  cgcd_pkg::t_job  i_job,
    output logic            o_push_ready,
    output logic            o_head_valid,
    output cgcd_pkg::t_job  o_head,
    input  logic            i_pop
);

    cgcd_pkg::t_job                r_mem [cgcd_pkg::QDEPTH];
    logic [cgcd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [cgcd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [cgcd_pkg::QPTR_W:0]     r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = r_count != (cgcd_pkg::QPTR_W + 1)'(cgcd_pkg::QDEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= cgcd_pkg::QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= cgcd_pkg::QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/cgcd_back.sv =====
module cgcd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  cgcd_pkg::t_job  i_head,
    output logic            o_pop,
    cgcd_res_if.source      o_res
);

    logic                          r_out_valid;
    logic                          r_phase;
    logic signed [cgcd_pkg::GRAD_W-1:0] r_grad;
    cgcd_pkg::t_row                r_row;
    logic [cgcd_pkg::RCOL_W-1:0]   r_col;
    logic                          r_last;
    logic                          r_done;
    logic                          load;

    assign load  = i_head_valid && (!r_out_valid || o_res.ready);
    assign o_pop = load && (r_phase || !i_head.last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_phase     <= r_phase ? 1'b0 : i_head.last_row;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_col <= cgcd_pkg::RCOL_W'(i_head.col);
            if (r_phase) begin
                r_grad <= i_head.grad_own;
                r_row  <= i_head.row;
                r_last <= 1'b1;
                r_done <= i_head.row_end;
            end else begin
                r_grad <= i_head.grad_up;
                r_row  <= cgcd_pkg::ROW_W'(i_head.row - 1'b1);
                r_last <= !i_head.last_row;
                r_done <= 1'b0;
            end
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.gradient_half_units = r_grad;
    assign o_res.result_row          = r_row;
    assign o_res.result_column       = r_col;
    assign o_res.last_of_run         = r_last;
    assign o_res.frame_done          = r_done;

    a_phase_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_head_valid)
        else $error("second result pending without a queued entry");

    a_last_row_splits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_phase && i_head.last_row) |=> r_phase)
        else $error("last-row entry not held for its own result");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_last)
        else $error("frame end flagged on a non-final result");

endmodule

// ===== design/column_gradient_central_difference.sv =====
// Vertical gradient by central differences over a raster pixel stream. Pixels enter in raster
// order through i_pix; each result on o_res is twice the vertical derivative of one pixel,
// so the value is exact: row 0 gets 2*(p[1]-p[0]), inner rows p[r+1]-p[r-1], the last row
// 2*(p[H-1]-p[H-2]). A result is known only once the pixel one row below arrives, so
// results run one row behind the input, and every pixel of the last row gives two results:
// the one for the row above (last_of_run low), then its own (last_of_run high, frame_done
// high on the frame's last column). Top row pixels give no result. The input takes one pixel
// per clock unless the full job queue holds it back; on the last row the output port gives
// two results per pixel and sets the pace there. An accepted pixel passes the line buffer
// read register, the two-entry job queue and the output register before its first result
// appears. Configure image_width (index 0, clamped to 1..1024) and image_height (index 1,
// at least 2) only while the block is idle; the line buffers need no clearing after reset.
module column_gradient_central_difference (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgcd_pix_if.sink    i_pix,
    cgcd_res_if.source  o_res,
    cgcd_cfg_if.sink    i_cfg
);

    cgcd_pkg::t_cfg  r_cfg;
    logic            push_valid;
    logic            push_ready;
    cgcd_pkg::t_job  push_job;
    logic            head_valid;
    cgcd_pkg::t_job  head_job;
    logic            pop;
    logic            cfg_wr;

    // Configuration transactions are always taken
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= cgcd_pkg::WIDTH_RESET;
            r_cfg.image_height <= cgcd_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                cgcd_pkg::REG_IMAGE_WIDTH:
                    r_cfg.image_width <= i_cfg.data[cgcd_pkg::WIDTH_W-1:0];
                cgcd_pkg::REG_IMAGE_HEIGHT:
                    r_cfg.image_height <= i_cfg.data[cgcd_pkg::HEIGHT_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Front: count position, read line buffers, classify each pixel into a job
    cgcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .o_job        (push_job),
        .i_push_ready (push_ready)
    );

    // Queue: decouple pixel intake from result delivery
    cgcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head_job),
        .i_pop        (pop)
    );

    // Back: emit one or two results per job through the output register
    cgcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule
